/* rtl/core/elc_pkg.sv */
// Shared types and constants for the envelope level control block.
package elc_pkg;

   localparam int TARGET_BITS    = 15;
   localparam int GAIN_BITS      = 16;
   localparam int COEFF_BITS     = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_ENABLE         = 3'd0,
      REG_TARGET_LEVEL   = 3'd1,
      REG_MAX_GAIN       = 3'd2,
      REG_MIN_GAIN       = 3'd3,
      REG_ATTACK_COEFF   = 3'd4,
      REG_RELEASE_COEFF  = 3'd5,
      REG_NULL_THRESHOLD = 3'd6
   } reg_index_type;

   localparam logic [TARGET_BITS-1:0] TARGET_LEVEL_RST   = 15'd16384;
   localparam logic [GAIN_BITS-1:0]   MAX_GAIN_RST       = 16'd32768;
   localparam logic [GAIN_BITS-1:0]   MIN_GAIN_RST       = 16'd1024;
   localparam logic [COEFF_BITS-1:0]  ATTACK_COEFF_RST   = 16'd655;
   localparam logic [COEFF_BITS-1:0]  RELEASE_COEFF_RST  = 16'd7;
   localparam logic [TARGET_BITS-1:0] NULL_THRESHOLD_RST = 15'd0;

   typedef struct packed {
      logic                   enable;
      logic [TARGET_BITS-1:0] target_level;
      logic [GAIN_BITS-1:0]   max_gain;
      logic [GAIN_BITS-1:0]   min_gain;
      logic [COEFF_BITS-1:0]  attack_coeff;
      logic [COEFF_BITS-1:0]  release_coeff;
      logic [TARGET_BITS-1:0] null_threshold;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic div_step;
      logic diff;
      logic mul_lo;
      logic mul_hi;
      logic sum;
      logic update;
      logic clamp;
      logic out_mul;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic enable;
      logic at_null;
      logic div_last;
      logic out_free;
   } sts_type;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_PREP   = 11'b00000000010,
      ST_DIV    = 11'b00000000100,
      ST_DIFF   = 11'b00000001000,
      ST_MULLO  = 11'b00000010000,
      ST_MULHI  = 11'b00000100000,
      ST_SUM    = 11'b00001000000,
      ST_UPDATE = 11'b00010000000,
      ST_CLAMP  = 11'b00100000000,
      ST_OUTMUL = 11'b01000000000,
      ST_FINISH = 11'b10000000000
   } state_type;

endpackage

/* rtl/core/elc_csr.sv */
// Configuration register file with gain restart on enable rising.
module elc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [elc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [elc_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   output elc_pkg::cfg_type                    cfg_o,
   output logic                                gain_reset_o
);

   elc_pkg::cfg_type cfg_ff;
   elc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            elc_pkg::REG_ENABLE:         cfg_in.enable = csr_write_data[0];
            elc_pkg::REG_TARGET_LEVEL:
               cfg_in.target_level = csr_write_data[elc_pkg::TARGET_BITS-1:0];
            elc_pkg::REG_MAX_GAIN:       cfg_in.max_gain = csr_write_data;
            elc_pkg::REG_MIN_GAIN:       cfg_in.min_gain = csr_write_data;
            elc_pkg::REG_ATTACK_COEFF:   cfg_in.attack_coeff = csr_write_data;
            elc_pkg::REG_RELEASE_COEFF:  cfg_in.release_coeff = csr_write_data;
            elc_pkg::REG_NULL_THRESHOLD:
               cfg_in.null_threshold = csr_write_data[elc_pkg::TARGET_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable         <= 1'b0;
         cfg_ff.target_level   <= elc_pkg::TARGET_LEVEL_RST;
         cfg_ff.max_gain       <= elc_pkg::MAX_GAIN_RST;
         cfg_ff.min_gain       <= elc_pkg::MIN_GAIN_RST;
         cfg_ff.attack_coeff   <= elc_pkg::ATTACK_COEFF_RST;
         cfg_ff.release_coeff  <= elc_pkg::RELEASE_COEFF_RST;
         cfg_ff.null_threshold <= elc_pkg::NULL_THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign gain_reset_o = csr_write_enable && (csr_index == elc_pkg::REG_ENABLE)
                         && csr_write_data[0] && !cfg_ff.enable;
   assign cfg_o = cfg_ff;

endmodule

/* rtl/core/elc_ctrl.sv */
// Sequencing state machine for the level control datapath.
module elc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  elc_pkg::sts_type sts_i,
   output elc_pkg::cmd_type cmd_o
);

   elc_pkg::state_type state_ff;
   elc_pkg::state_type state_in;
   logic               accept;

   assign accept    = req_valid && (state_ff == elc_pkg::ST_IDLE);
   assign req_stall = (state_ff != elc_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         elc_pkg::ST_IDLE:   if (accept) state_in = elc_pkg::ST_PREP;
         elc_pkg::ST_PREP: begin
            if (!sts_i.enable)
               state_in = elc_pkg::ST_FINISH;
            else if (sts_i.at_null)
               state_in = elc_pkg::ST_DIFF;
            else
               state_in = elc_pkg::ST_DIV;
         end
         elc_pkg::ST_DIV:    if (sts_i.div_last) state_in = elc_pkg::ST_DIFF;
         elc_pkg::ST_DIFF:   state_in = elc_pkg::ST_MULLO;
         elc_pkg::ST_MULLO:  state_in = elc_pkg::ST_MULHI;
         elc_pkg::ST_MULHI:  state_in = elc_pkg::ST_SUM;
         elc_pkg::ST_SUM:    state_in = elc_pkg::ST_UPDATE;
         elc_pkg::ST_UPDATE: state_in = elc_pkg::ST_CLAMP;
         elc_pkg::ST_CLAMP:  state_in = elc_pkg::ST_OUTMUL;
         elc_pkg::ST_OUTMUL: state_in = elc_pkg::ST_FINISH;
         elc_pkg::ST_FINISH: if (sts_i.out_free) state_in = elc_pkg::ST_IDLE;
         default:            state_in = elc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= elc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd_o.load     = accept;
      cmd_o.prep     = (state_ff == elc_pkg::ST_PREP);
      cmd_o.div_step = (state_ff == elc_pkg::ST_DIV);
      cmd_o.diff     = (state_ff == elc_pkg::ST_DIFF);
      cmd_o.mul_lo   = (state_ff == elc_pkg::ST_MULLO);
      cmd_o.mul_hi   = (state_ff == elc_pkg::ST_MULHI);
      cmd_o.sum      = (state_ff == elc_pkg::ST_SUM);
      cmd_o.update   = (state_ff == elc_pkg::ST_UPDATE);
      cmd_o.clamp    = (state_ff == elc_pkg::ST_CLAMP);
      cmd_o.out_mul  = (state_ff == elc_pkg::ST_OUTMUL);
      cmd_o.finish   = (state_ff == elc_pkg::ST_FINISH) && sts_i.out_free;
   end

   a_accept_to_prep: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == elc_pkg::ST_PREP))
      else $error("accepted beat did not start preparation");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == elc_pkg::ST_FINISH && !sts_i.out_free) |=> (state_ff == elc_pkg::ST_FINISH))
      else $error("finish left while result register busy");

   a_div_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == elc_pkg::ST_DIV && !sts_i.div_last) |=> (state_ff == elc_pkg::ST_DIV))
      else $error("divide ended early");

endmodule

/* rtl/core/elc_dp.sv */
// Datapath: magnitude, saturating divider, gain smoothing, clamp and output scaling.
module elc_dp #(
   parameter int SAMPLE_BITS          = 16,
   parameter int GAIN_EXTRA_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  elc_pkg::cfg_type              cfg_i,
   input  logic                          gain_reset_i,
   input  elc_pkg::cmd_type              cmd_i,
   output elc_pkg::sts_type              sts_o,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic signed [SAMPLE_BITS-1:0] rsp_leveled_sample,
   output logic [elc_pkg::GAIN_BITS-1:0] rsp_gain_now
);

   localparam int SB          = SAMPLE_BITS;
   localparam int E           = GAIN_EXTRA_FRAC_BITS;
   localparam int GW          = 16 + E;
   localparam int F           = 12 + E;
   localparam int QW          = GW + 1;
   localparam int SH          = E + SB - 4;
   localparam int DIV_BITS    = 15 + SH;
   localparam int DIV_STEPS   = DIV_BITS + (DIV_BITS % 2);
   localparam int DIV_CYCLES  = DIV_STEPS / 2;
   localparam int CNT_W       = $clog2(DIV_CYCLES);
   localparam bit DVD_PAD     = (DIV_BITS % 2) == 1;
   localparam int CW          = (SB > 16) ? SB : 16;
   localparam int MAG_SH      = (SB < 16) ? 16 - SB : 0;
   localparam int NUL_SH      = (SB > 16) ? SB - 16 : 0;
   localparam int HL          = (GW + 1) / 2;
   localparam int HH          = GW - HL;
   localparam int PW          = SB + 17;
   localparam int OW          = PW - 12;
   localparam logic [GW-1:0] GAIN_ONE = GW'(64'd1 << F);
   localparam logic [OW-1:0] LIM_NEG  = OW'(64'd1 << (SB - 1));
   localparam logic [OW-1:0] LIM_POS  = OW'((64'd1 << (SB - 1)) - 64'd1);
   localparam logic [PW-1:0] ROUND    = PW'(2048);

   // item registers
   logic [SB-1:0]    raw_ff, mag_ff;
   logic             neg_ff, at_null_ff;
   // divider
   logic [SB-1:0]    rem_ff, rem_in;
   logic [QW-1:0]    q_ff, q_in;
   logic             over_ff, over_in;
   logic [15:0]      dvd_ff, dvd_in;
   logic [CNT_W-1:0] cnt_ff;
   // smoothing
   logic             dec_ff, dec_in;
   logic [GW-1:0]    diff_ff, diff_in;
   logic [15:0]      coeff_ff;
   logic [HL+15:0]   plo_ff, plo_in;
   logic [HH+15:0]   phi_ff, phi_in;
   logic [GW-1:0]    add_ff, add_in;
   logic [GW-1:0]    gain_ff, gain_in;
   logic [PW-1:0]    prod_ff, prod_in;
   // result register
   logic             rsp_valid_ff;
   logic [SB-1:0]    rsp_sample_ff, rsp_sample_in;
   logic [15:0]      rsp_gain_ff;

   logic [SB-1:0]    raw_in, mag_in;
   logic [GW-1:0]    maxg, ming, desired, gain_clamped, gain_lo_clamped;
   logic [GW:0]      sub_gd;
   logic [CW-1:0]    mag_cmp, nul_cmp;
   logic             at_null;
   logic [GW+15:0]   sum_full;
   logic [OW-1:0]    prod_sh, lim, prod_sat;
   logic [SB-1:0]    lev;
   logic             out_free;

   assign raw_in = req_sample;
   assign mag_in = raw_in[SB-1] ? SB'(~raw_in + SB'(1)) : raw_in;

   assign maxg = GW'(cfg_i.max_gain) << E;
   assign ming = GW'(cfg_i.min_gain) << E;

   assign mag_cmp = CW'(mag_ff) << MAG_SH;
   assign nul_cmp = CW'(cfg_i.null_threshold) << NUL_SH;
   assign at_null = (mag_cmp <= nul_cmp);

   // two restoring steps per cycle, quotient frozen once above the cap
   always_comb begin
      logic [SB:0]   r_sh;
      logic [SB-1:0] r;
      logic [QW-1:0] q;
      logic          ov;
      logic [15:0]   d;
      logic          ge;
      r  = rem_ff;
      q  = q_ff;
      ov = over_ff;
      d  = dvd_ff;
      for (int k = 0; k < 2; k++) begin
         r_sh = {r, d[15]};
         d    = {d[14:0], 1'b0};
         ge   = (r_sh >= {1'b0, mag_ff});
         if (ge) begin
            r_sh = r_sh - {1'b0, mag_ff};
         end
         r = r_sh[SB-1:0];
         if (!ov) begin
            q = {q[QW-2:0], ge};
         end
         if (q > {1'b0, maxg}) begin
            ov = 1'b1;
         end
      end
      rem_in  = r;
      q_in    = q;
      over_in = ov;
      dvd_in  = d;
   end

   assign desired = (at_null_ff || over_ff) ? maxg : q_ff[GW-1:0];
   assign sub_gd  = {1'b0, gain_ff} - {1'b0, desired};
   assign dec_in  = (desired < gain_ff);
   assign diff_in = dec_in ? sub_gd[GW-1:0] : (desired - gain_ff);

   assign plo_in   = (HL+16)'(diff_ff[HL-1:0]) * (HL+16)'(coeff_ff);
   assign phi_in   = (HH+16)'(diff_ff[GW-1:HL]) * (HH+16)'(coeff_ff);
   assign sum_full = ((GW+16)'(phi_ff) << HL) + (GW+16)'(plo_ff);
   assign add_in   = sum_full[GW+15:16];

   assign gain_lo_clamped = (gain_ff < ming) ? ming : gain_ff;
   assign gain_clamped    = (gain_lo_clamped > maxg) ? maxg : gain_lo_clamped;

   always_comb begin
      gain_in = gain_ff;
      if (gain_reset_i) begin
         gain_in = GAIN_ONE;
      end else if (cmd_i.update) begin
         gain_in = dec_ff ? (gain_ff - add_ff) : (gain_ff + add_ff);
      end else if (cmd_i.clamp) begin
         gain_in = gain_clamped;
      end
   end

   assign prod_in = PW'(mag_ff) * PW'(gain_ff[E+15:E]) + ROUND;

   assign prod_sh  = prod_ff[PW-1:12];
   assign lim      = neg_ff ? LIM_NEG : LIM_POS;
   assign prod_sat = (prod_sh > lim) ? lim : prod_sh;
   assign lev      = neg_ff ? SB'(SB'(0) - prod_sat[SB-1:0]) : prod_sat[SB-1:0];
   assign rsp_sample_in = cfg_i.enable ? lev : raw_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_ONE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         gain_ff <= gain_in;
         if (cmd_i.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd_i.prep) begin
            cnt_ff <= '0;
         end else if (cmd_i.div_step) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         raw_ff <= raw_in;
         mag_ff <= mag_in;
         neg_ff <= raw_in[SB-1];
      end
      if (cmd_i.prep) begin
         at_null_ff <= at_null;
         rem_ff     <= '0;
         q_ff       <= '0;
         over_ff    <= 1'b0;
         dvd_ff     <= DVD_PAD ? {1'b0, cfg_i.target_level} : {cfg_i.target_level, 1'b0};
      end else if (cmd_i.div_step) begin
         rem_ff  <= rem_in;
         q_ff    <= q_in;
         over_ff <= over_in;
         dvd_ff  <= dvd_in;
      end
      if (cmd_i.diff) begin
         dec_ff   <= dec_in;
         diff_ff  <= diff_in;
         coeff_ff <= dec_in ? cfg_i.attack_coeff : cfg_i.release_coeff;
      end
      if (cmd_i.mul_lo) begin
         plo_ff <= plo_in;
      end
      if (cmd_i.mul_hi) begin
         phi_ff <= phi_in;
      end
      if (cmd_i.sum) begin
         add_ff <= add_in;
      end
      if (cmd_i.out_mul) begin
         prod_ff <= prod_in;
      end
      if (cmd_i.finish) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_gain_ff   <= gain_ff[E+15:E];
      end
   end

   always_comb begin
      sts_o.enable   = cfg_i.enable;
      sts_o.at_null  = at_null;
      sts_o.div_last = (cnt_ff == CNT_W'(DIV_CYCLES - 1));
      sts_o.out_free = out_free;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_leveled_sample = rsp_sample_ff;
   assign rsp_gain_now       = rsp_gain_ff;

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd_i.finish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

   a_clamp_bound: assert property (@(posedge clock) disable iff (reset)
      cmd_i.clamp |=> (gain_ff <= maxg))
      else $error("gain above maximum after clamp");

endmodule

/* rtl/core/envelope_level_control.sv */
// Envelope level control top level: attack/release gain with saturated scaling.
// Enabled: each input beat passes PREP, the two-bit-per-cycle restoring divider (DIV),
//   then DIFF, MULLO, MULHI, SUM, UPDATE, CLAMP, OUTMUL and FINISH; no new beat is taken until done.
// At or below the null threshold the divide is skipped and DIFF follows PREP directly.
// Disabled: PREP goes straight to FINISH. FINISH waits while the result register is stalled.
// Synchronous reset restores defaults and a gain of 1.0.
module envelope_level_control #(
   parameter int SAMPLE_BITS          = 16,
   parameter int GAIN_EXTRA_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]       rsp_leveled_sample,
   output logic [elc_pkg::GAIN_BITS-1:0]       rsp_gain_now,
   input  logic                                csr_write_enable,
   input  logic [elc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [elc_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   elc_pkg::cfg_type cfg;
   elc_pkg::cmd_type cmd;
   elc_pkg::sts_type sts;
   logic             gain_reset;

   elc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg_o            (cfg),
      .gain_reset_o     (gain_reset)
   );

   elc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts_i     (sts),
      .cmd_o     (cmd)
   );

   elc_dp #(
      .SAMPLE_BITS          (SAMPLE_BITS),
      .GAIN_EXTRA_FRAC_BITS (GAIN_EXTRA_FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg_i              (cfg),
      .gain_reset_i       (gain_reset),
      .cmd_i              (cmd),
      .sts_o              (sts),
      .req_sample         (req_sample),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_leveled_sample (rsp_leveled_sample),
      .rsp_gain_now       (rsp_gain_now)
   );

endmodule

/* tb/envelope_level_control_check.sv */
// Gain tracker and result checker for the envelope level control block.
module envelope_level_control_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [15:0]                  req_sample,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [15:0]                  rsp_leveled_sample,
   input  logic [elc_pkg::GAIN_BITS-1:0]       rsp_gain_now,
   input  logic                                csr_write_enable,
   input  logic [elc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [elc_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   output int                                  mismatch_count,
   output int                                  outstanding
);
   import elc_pkg::*;

   localparam int          EXTRA_BITS  = 16;
   localparam int          GAIN_FRAC   = 12 + EXTRA_BITS;
   localparam logic [63:0] UNITY_GAIN  = 64'd1 << GAIN_FRAC;
   localparam int          PRINT_LIMIT = 100;

   typedef struct packed {
      logic signed [15:0]   leveled_sample;
      logic [GAIN_BITS-1:0] gain_now;
   } leveled_beat_t;

   cfg_type       settings;
   logic [63:0]   held_gain;
   leveled_beat_t expected_beats[$];
   int            tally = 0;

   assign mismatch_count = tally;

   task automatic report_mismatch(input string line);
      if (tally < PRINT_LIMIT) $display("%0t  %s", $time, line);
      tally++;
   endtask

   task automatic write_setting(input logic [CSR_INDEX_BITS-1:0] idx,
                                input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         REG_ENABLE: begin
            if (data[0] && !settings.enable) held_gain = UNITY_GAIN;
            settings.enable = data[0];
         end
         REG_TARGET_LEVEL:   settings.target_level   = data[TARGET_BITS-1:0];
         REG_MAX_GAIN:       settings.max_gain       = data[GAIN_BITS-1:0];
         REG_MIN_GAIN:       settings.min_gain       = data[GAIN_BITS-1:0];
         REG_ATTACK_COEFF:   settings.attack_coeff   = data[COEFF_BITS-1:0];
         REG_RELEASE_COEFF:  settings.release_coeff  = data[COEFF_BITS-1:0];
         REG_NULL_THRESHOLD: settings.null_threshold = data[TARGET_BITS-1:0];
         default: ;
      endcase
   endtask

   // One gain step; held_gain is Q4.28, results carry the truncated Q4.12 gain.
   task automatic step_gain(input logic signed [15:0] s, output leveled_beat_t beat);
      logic        negative;
      logic [63:0] mag, ceiling, floor_gain, desired, g12, prod;
      negative = s[15];
      mag = negative ? 64'd65536 - {48'd0, s} : {48'd0, s};
      if (!settings.enable) begin
         beat.leveled_sample = s;
         beat.gain_now       = held_gain[31:16];
      end else begin
         ceiling    = {48'd0, settings.max_gain} << EXTRA_BITS;
         floor_gain = {48'd0, settings.min_gain} << EXTRA_BITS;
         // zero magnitude always lands here
         if (mag <= {49'd0, settings.null_threshold}) begin
            desired = ceiling;
         end else begin
            desired = ({49'd0, settings.target_level} << GAIN_FRAC) / mag;
            if (desired > ceiling) desired = ceiling;
         end
         if (desired < held_gain)
            held_gain = held_gain
                      - (((held_gain - desired) * {48'd0, settings.attack_coeff}) >> 16);
         else
            held_gain = held_gain
                      + (((desired - held_gain) * {48'd0, settings.release_coeff}) >> 16);
         if (held_gain < floor_gain) held_gain = floor_gain;
         if (held_gain > ceiling) held_gain = ceiling;
         g12  = {48'd0, held_gain[31:16]};
         prod = (mag * g12 + 64'd2048) >> 12;
         if (negative) begin
            if (prod > 64'd32768) prod = 64'd32768;
            beat.leveled_sample = 16'(64'd65536 - prod);
         end else begin
            if (prod > 64'd32767) prod = 64'd32767;
            beat.leveled_sample = prod[15:0];
         end
         beat.gain_now = g12[15:0];
      end
   endtask

   always @(posedge clock) begin
      leveled_beat_t fresh, oldest;
      if (reset) begin
         settings = '{enable: 1'b0, target_level: TARGET_LEVEL_RST, max_gain: MAX_GAIN_RST,
                      min_gain: MIN_GAIN_RST, attack_coeff: ATTACK_COEFF_RST,
                      release_coeff: RELEASE_COEFF_RST, null_threshold: NULL_THRESHOLD_RST};
         held_gain = UNITY_GAIN;
         expected_beats.delete();
      end else begin
         if (csr_write_enable) write_setting(csr_index, csr_write_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               report_mismatch($sformatf("result beat %0d/%0d with nothing expected",
                                         rsp_leveled_sample, rsp_gain_now));
            end else begin
               oldest = expected_beats.pop_front();
               if (rsp_leveled_sample !== oldest.leveled_sample)
                  report_mismatch($sformatf("leveled_sample %0d, expected %0d",
                                            rsp_leveled_sample, oldest.leveled_sample));
               if (rsp_gain_now !== oldest.gain_now)
                  report_mismatch($sformatf("gain_now %0d, expected %0d",
                                            rsp_gain_now, oldest.gain_now));
            end
         end
         if (req_valid && !req_stall) begin
            step_gain(req_sample, fresh);
            expected_beats.push_back(fresh);
         end
      end
      outstanding <= expected_beats.size();
   end

endmodule

/* tb/envelope_level_control_test.sv */
// Stimulus, handshake pacing and verdict for the envelope level control block.
module envelope_level_control_test;
   import elc_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE = 3'd7;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SQUEEZE_CYCLES = 400;
   localparam int SEGMENTS       = 9;
   localparam int SEGMENT_ITEMS  = 100;
   localparam int DRAIN_CYCLES   = 64;

   typedef enum {STALL_NONE, STALL_COIN, STALL_COMB, STALL_CHOKE} stall_mode_t;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [15:0]        req_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [15:0]        rsp_leveled_sample;
   logic [GAIN_BITS-1:0]      rsp_gain_now;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_write_data = '0;
   int                        mismatch_count;
   int                        outstanding;

   int                     burst_left = 0;
   int                     idle_cycles = 0;
   int                     level = 4000;
   logic [TARGET_BITS-1:0] null_copy = '0;
   logic                   enabled_copy = 1'b0;
   logic                   random_phase = 1'b0;
   logic                   squeezed = 1'b0;

   envelope_level_control dut (.*);
   envelope_level_control_check watcher (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      if (idx == REG_NULL_THRESHOLD) null_copy = data[TARGET_BITS-1:0];
      if (idx == REG_ENABLE) enabled_copy = data[0];
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // bursts of beats with random gaps between them
   task automatic offer_sample(input logic signed [15:0] s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         case ($urandom_range(0, 3))
            0, 1: gap = 0;
            2: gap = $urandom_range(1, 6);
            default: gap = $urandom_range(7, 45);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [15:0] with_sign(input int m);
      if ($urandom_range(0, 1)) return 16'(-m);
      return 16'(m > 32767 ? 32767 : m);
   endfunction

   // half the time envelope-like runs around a drifting level so the gain settles
   function automatic logic [15:0] pick_sample();
      int m;
      if ($urandom_range(0, 39) == 0) level = $urandom_range(0, 32768);
      case ($urandom_range(0, 9))
         0, 1: return 16'($urandom);
         2: case ($urandom_range(0, 4))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               3: return 16'hFFFF;
               default: return 16'h0001;
            endcase
         3: begin
            m = int'(null_copy) + int'($urandom_range(0, 2)) - 1;
            return with_sign(m < 0 ? 0 : m);
         end
         4: return with_sign($urandom_range(0, 255));
         default: begin
            m = level + int'($urandom_range(0, 200)) - 100;
            if (m < 0) m = 0;
            if (m > 32768) m = 32768;
            return with_sign(m);
         end
      endcase
   endfunction

   function automatic logic [15:0] pick_gain(input int lo, input int hi);
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(lo, hi));
      endcase
   endfunction

   task automatic shuffle_settings(input int seg);
      logic [CSR_DATA_BITS-1:0] word;
      word = $urandom;
      write_reg(REG_TARGET_LEVEL,
                ($urandom_range(0, 3) == 0) ? word : 16'($urandom_range(1, 32767)));
      write_reg(REG_MAX_GAIN, pick_gain(4096, 65535));
      write_reg(REG_MIN_GAIN, pick_gain(0, 8192));
      write_reg(REG_ATTACK_COEFF, pick_gain(0, 65535));
      write_reg(REG_RELEASE_COEFF, pick_gain(0, 2000));
      case ($urandom_range(0, 3))
         0: write_reg(REG_NULL_THRESHOLD, 16'h0000);
         1: write_reg(REG_NULL_THRESHOLD, 16'($urandom));
         default: write_reg(REG_NULL_THRESHOLD, 16'($urandom_range(0, 600)));
      endcase
      if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, 16'($urandom));
      if (seg % 4 == 3) begin
         write_reg(REG_ENABLE, {15'($urandom), 1'b0});
      end else begin
         // either a plain rewrite of enable or an off/on pair that restarts the gain
         if (enabled_copy && $urandom_range(0, 1)) write_reg(REG_ENABLE, 16'h0000);
         write_reg(REG_ENABLE, {15'($urandom), 1'b1});
      end
      end_writes();
   endtask

   initial begin
      stall_mode_t mode;
      int          span, period, step;
      @(posedge clock);
      forever begin
         if (random_phase && !squeezed && outstanding != 0) begin
            squeezed = 1'b1;
            rsp_stall <= 1'b1;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
         end else begin
            mode   = stall_mode_t'($urandom_range(0, 3));
            span   = $urandom_range(16, 200);
            period = $urandom_range(2, 9);
            for (step = 0; step < span; step++) begin
               case (mode)
                  STALL_NONE:  rsp_stall <= 1'b0;
                  STALL_COIN:  rsp_stall <= 1'($urandom_range(0, 1));
                  STALL_COMB:  rsp_stall <= (step % period) == 0;
                  default:     rsp_stall <= ($urandom_range(0, 7) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      int seg;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // disabled: straight pass-through at unity gain
      offer_sample(16'sd0);
      offer_sample(16'sh7FFF);
      offer_sample(16'sh8000);
      offer_sample(-16'sd1);
      offer_sample(16'sd1);
      settle();

      write_reg(REG_ENABLE, 16'h0001);
      end_writes();
      offer_sample(16'sd0);
      offer_sample(16'sh7FFF);
      offer_sample(16'sh8000);
      offer_sample(-16'sd1);
      offer_sample(16'sd1);
      offer_sample(16'sd16384);
      offer_sample(-16'sd16384);
      offer_sample(16'sd100);
      settle();

      // top of every range but the minimum gain (zero), high bits of the 15-bit registers dropped
      write_reg(REG_TARGET_LEVEL, 16'hFFFF);
      write_reg(REG_MAX_GAIN, 16'hFFFF);
      write_reg(REG_MIN_GAIN, 16'h0000);
      write_reg(REG_ATTACK_COEFF, 16'hFFFF);
      write_reg(REG_RELEASE_COEFF, 16'hFFFF);
      write_reg(REG_NULL_THRESHOLD, 16'hFFFF);
      write_reg(REG_SPARE, 16'hFFFF);
      end_writes();
      offer_sample(16'sd1000);
      offer_sample(16'sh8000);
      offer_sample(16'sh7FFF);
      settle();

      // min above max, frozen coefficients, zero target
      write_reg(REG_TARGET_LEVEL, 16'h0000);
      write_reg(REG_MAX_GAIN, 16'd8192);
      write_reg(REG_MIN_GAIN, 16'd40000);
      write_reg(REG_ATTACK_COEFF, 16'h0000);
      write_reg(REG_RELEASE_COEFF, 16'h0000);
      write_reg(REG_NULL_THRESHOLD, 16'h0000);
      end_writes();
      offer_sample(16'sd5000);
      offer_sample(-16'sd5000);
      offer_sample(16'sd0);
      settle();

      // enable rewritten while on keeps the gain; off holds it; on again restarts
      write_reg(REG_TARGET_LEVEL, 16'd8000);
      write_reg(REG_MIN_GAIN, 16'h0000);
      write_reg(REG_MAX_GAIN, 16'hFFFF);
      write_reg(REG_RELEASE_COEFF, 16'd30000);
      write_reg(REG_ENABLE, 16'hFFFF);
      end_writes();
      offer_sample(16'sd300);
      settle();
      write_reg(REG_ENABLE, 16'h0000);
      end_writes();
      offer_sample(-16'sd7);
      offer_sample(16'sh7FFF);
      settle();
      write_reg(REG_ENABLE, 16'h0001);
      end_writes();
      offer_sample(16'sd12345);
      settle();

      random_phase = 1'b1;
      for (seg = 0; seg < SEGMENTS; seg++) begin
         level = $urandom_range(0, 32768);
         shuffle_settings(seg);
         repeat (SEGMENT_ITEMS) offer_sample(pick_sample());
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
